FILE: hdl/lrgc_pkg.sv
// Shared constants and widths for the linear resampler with gain and clamp.
package lrgc_pkg;

  // Sample and phase formats
  localparam int SAMPLE_W = 16;
  localparam int FRAC_W = 16;
  localparam int PHASE_W = FRAC_W + 2;
  localparam int RATE_W = 17;
  localparam int MAX_OUTPUTS = 12;
  localparam int CNT_W = $clog2(MAX_OUTPUTS);

  // Source rate limits and reset value
  localparam logic [RATE_W-1:0] RATE_MIN = RATE_W'(4000);
  localparam logic [RATE_W-1:0] RATE_MAX = RATE_W'(96000);
  localparam logic [RATE_W-1:0] RATE_RESET = RATE_W'(8000);

  // Phase step: ceil(rate * 2^16 / 48000) = ceil(rate * 512 / 375),
  // taken as ((rate * 512 + 374) * RECIP) >> RECIP_SHIFT, exact for this range
  localparam int STEP_DEN = 375;
  localparam int STEP_SHIFT = FRAC_W - 7;
  localparam int DIVIDEND_W = 26;
  localparam int RECIP_SHIFT = 34;
  localparam logic [DIVIDEND_W-1:0] RECIP = DIVIDEND_W'(45812985);

  // Shared multiplier operand and product widths
  localparam int MUL_W = 27;
  localparam int PROD_W = 2 * MUL_W;

  // Interpolated value, gained value and clamp magnitude
  localparam int Y_W = 35;
  localparam int MAG_W = FRAC_W + SAMPLE_W + 1;
  localparam int SCALED_W = MAG_W + 15;

  // APB address width: one 32-bit register
  localparam int ADDR_W = 3;
  localparam logic REG_SOURCE_RATE = 1'b0;

endpackage

FILE: hdl/linear_resampler_gain_clamp_48k.sv
// Linear resampler to 48 kHz with 2.5x gain, clamp and rounding; top level.
//
// Each input sample is paired with the one before it and 48 kHz outputs are
// interpolated at a 16-fraction-bit phase, gained by 2.5, clamped to full scale,
// scaled by 32767/32768 and rounded half away from zero. The block handles one
// input at a time: in_ready is high only while idle. An input that makes no
// output (first sample after reset or restart, or a skipped sample) is taken
// without leaving idle. An input that makes N outputs (1 to 12) is accepted
// while idle, then the phase step is derived on the shared multiplier, then
// each output is multiplied, gained, clamped, rounded and presented, and held
// while out_ready is low; the next input is accepted only after the final
// output. At the 8 kHz reset rate an input usually makes six outputs.
// The one 27x27 multiplier is reused for the step and for each interpolation
// product.
// The source rate register sits at byte address 0 and is clamped to
// 4000..96000 Hz at use.
module linear_resampler_gain_clamp_48k (
  input  logic                                  clk,
  input  logic                                  rst,
  // Input samples
  input  logic                                  in_valid,
  output logic                                  in_ready,
  input  logic signed [lrgc_pkg::SAMPLE_W-1:0]  sample_in,
  input  logic                                  restart,
  // Output samples
  output logic                                  out_valid,
  input  logic                                  out_ready,
  output logic signed [lrgc_pkg::SAMPLE_W-1:0]  sample_out,
  output logic                                  last,
  // APB configuration
  input  logic                                  psel,
  input  logic                                  penable,
  input  logic                                  pwrite,
  input  logic [lrgc_pkg::ADDR_W-1:0]           paddr,
  input  logic [31:0]                           pwdata,
  output logic [31:0]                           prdata,
  output logic                                  pready
);

  localparam logic [2:0] S_IDLE = 3'd0;
  localparam logic [2:0] S_STEP = 3'd1;
  localparam logic [2:0] S_LOAD = 3'd2;
  localparam logic [2:0] S_MUL  = 3'd3;
  localparam logic [2:0] S_GAIN = 3'd4;
  localparam logic [2:0] S_SAT  = 3'd5;
  localparam logic [2:0] S_RND  = 3'd6;
  localparam logic [2:0] S_HOLD = 3'd7;

  localparam logic [lrgc_pkg::PHASE_W-1:0] ONE =
    lrgc_pkg::PHASE_W'(1) << lrgc_pkg::FRAC_W;
  localparam logic signed [lrgc_pkg::Y_W-1:0] LIM =
    lrgc_pkg::Y_W'(1) << (lrgc_pkg::FRAC_W + lrgc_pkg::SAMPLE_W);
  localparam logic [lrgc_pkg::SCALED_W-1:0] HALF =
    lrgc_pkg::SCALED_W'(1) << (lrgc_pkg::FRAC_W + lrgc_pkg::SAMPLE_W - 1);

  logic [2:0]                              state;
  logic [lrgc_pkg::RATE_W-1:0]             rate;
  logic signed [lrgc_pkg::SAMPLE_W-1:0]    prev;
  logic signed [lrgc_pkg::SAMPLE_W-1:0]    cur;
  logic                                    have_prev;
  logic [lrgc_pkg::PHASE_W-1:0]            phase;
  logic [lrgc_pkg::PHASE_W-1:0]            step;
  logic [lrgc_pkg::DIVIDEND_W-1:0]         dividend;
  logic [lrgc_pkg::CNT_W-1:0]              cnt;
  logic signed [lrgc_pkg::PROD_W-1:0]      prod;
  logic signed [lrgc_pkg::Y_W-1:0]         gained;
  logic [lrgc_pkg::MAG_W-1:0]              mag;
  logic                                    neg;

  logic signed [lrgc_pkg::MUL_W-1:0]       mul_a;
  logic signed [lrgc_pkg::MUL_W-1:0]       mul_b;
  logic signed [lrgc_pkg::SAMPLE_W:0]      diff;
  logic [lrgc_pkg::RATE_W-1:0]             rate_clamped;
  logic signed [lrgc_pkg::Y_W-1:0]         y;
  logic [lrgc_pkg::SCALED_W-1:0]           scaled;
  logic [lrgc_pkg::SCALED_W-1:0]           rounded;
  logic [lrgc_pkg::SAMPLE_W-1:0]           q;
  logic [lrgc_pkg::PHASE_W-1:0]            phase_adv;
  logic                                    in_fire;
  logic                                    out_fire;
  logic                                    cfg_write;

  assign in_ready  = (state == S_IDLE);
  assign in_fire   = in_valid && in_ready;
  assign out_fire  = out_valid && out_ready;
  assign pready    = 1'b1;
  assign cfg_write = psel && penable && pwrite && pready;

  // Read back the rate register
  assign prdata = (paddr[2] == lrgc_pkg::REG_SOURCE_RATE) ? 32'(rate) : 32'd0;

  // Clamp the rate to RATE_MIN..RATE_MAX
  always_comb begin
    rate_clamped = rate;
    if (rate < lrgc_pkg::RATE_MIN) begin
      rate_clamped = lrgc_pkg::RATE_MIN;
    end else if (rate > lrgc_pkg::RATE_MAX) begin
      rate_clamped = lrgc_pkg::RATE_MAX;
    end
  end

  // Select shared multiplier operands
  assign diff = (lrgc_pkg::SAMPLE_W + 1)'(cur) - (lrgc_pkg::SAMPLE_W + 1)'(prev);
  always_comb begin
    if (state == S_STEP) begin
      mul_a = signed'({1'b0, dividend});
      mul_b = signed'({1'b0, lrgc_pkg::RECIP});
    end else begin
      mul_a = lrgc_pkg::MUL_W'(diff);
      mul_b = signed'(lrgc_pkg::MUL_W'(phase[lrgc_pkg::FRAC_W-1:0]));
    end
  end

  // Interpolate, scale by 32767 and round the magnitude
  assign y = (lrgc_pkg::Y_W'(prev) <<< lrgc_pkg::FRAC_W) + prod[lrgc_pkg::Y_W-1:0];
  assign scaled = (lrgc_pkg::SCALED_W'(mag) << 15) - lrgc_pkg::SCALED_W'(mag);
  assign rounded = scaled + HALF;
  assign q = rounded[lrgc_pkg::SCALED_W-1 -: lrgc_pkg::SAMPLE_W];
  assign phase_adv = phase + step;

  // Configuration register
  always_ff @(posedge clk) begin
    if (rst) begin
      rate <= lrgc_pkg::RATE_RESET;
    end else if (cfg_write && paddr[2] == lrgc_pkg::REG_SOURCE_RATE) begin
      rate <= pwdata[lrgc_pkg::RATE_W-1:0];
    end
  end

  // Shared multiplier, registered product
  always_ff @(posedge clk) begin
    prod <= lrgc_pkg::PROD_W'(mul_a) * lrgc_pkg::PROD_W'(mul_b);
  end

  // Sequencer and state
  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      prev      <= '0;
      have_prev <= 1'b0;
      phase     <= '0;
      out_valid <= 1'b0;
      cnt       <= '0;
    end else begin
      unique case (state)
        S_IDLE: begin
          if (in_fire) begin
            cur      <= sample_in;
            cnt      <= '0;
            dividend <= (lrgc_pkg::DIVIDEND_W'(rate_clamped) << lrgc_pkg::STEP_SHIFT)
                        + lrgc_pkg::DIVIDEND_W'(lrgc_pkg::STEP_DEN - 1);
            priority if (restart || !have_prev) begin
              // First sample or restart: keep it, no output
              prev      <= sample_in;
              have_prev <= 1'b1;
              phase     <= '0;
            end else if (phase >= ONE) begin
              // Skip: drop one period
              phase <= phase - ONE;
              prev  <= sample_in;
            end else begin
              state <= S_STEP;
            end
          end
        end
        S_STEP: begin
          state <= S_LOAD;
        end
        S_LOAD: begin
          step  <= prod[lrgc_pkg::RECIP_SHIFT +: lrgc_pkg::PHASE_W];
          state <= S_MUL;
        end
        S_MUL: begin
          state <= S_GAIN;
        end
        S_GAIN: begin
          gained <= (y <<< 2) + y;
          state  <= S_SAT;
        end
        S_SAT: begin
          // Clamp to full scale and split sign and magnitude
          neg <= gained[lrgc_pkg::Y_W-1];
          priority if (gained > LIM) begin
            mag <= lrgc_pkg::MAG_W'(LIM);
          end else if (gained < -LIM) begin
            mag <= lrgc_pkg::MAG_W'(LIM);
          end else if (gained[lrgc_pkg::Y_W-1]) begin
            mag <= lrgc_pkg::MAG_W'(-gained);
          end else begin
            mag <= lrgc_pkg::MAG_W'(gained);
          end
          state <= S_RND;
        end
        S_RND: begin
          sample_out <= neg ? -signed'(q) : signed'(q);
          last       <= (phase_adv >= ONE) ||
                        (cnt == lrgc_pkg::CNT_W'(lrgc_pkg::MAX_OUTPUTS - 1));
          phase      <= phase_adv;
          cnt        <= cnt + 1'b1;
          out_valid  <= 1'b1;
          state      <= S_HOLD;
        end
        S_HOLD: begin
          if (out_fire) begin
            out_valid <= 1'b0;
            if (last) begin
              // Close the input: wrap the phase or drop it after the cap
              phase <= (phase >= ONE) ? phase - ONE : '0;
              prev  <= cur;
              state <= S_IDLE;
            end else begin
              state <= S_MUL;
            end
          end
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

`ifndef SYNTHESIS
  // A result is shown only while the sequencer holds it
  assert property (@(posedge clk) disable iff (rst) out_valid |-> state == S_HOLD)
    else $error("out_valid outside the hold state");

  // Never take a new input while a result is pending
  assert property (@(posedge clk) disable iff (rst) !(in_ready && out_valid))
    else $error("input accepted while a result is pending");

  // The final result of an input returns the block to idle
  assert property (@(posedge clk) disable iff (rst)
    (out_valid && out_ready && last) |=> in_ready)
    else $error("block not idle after the final result");

  // Phase never reaches three periods
  assert property (@(posedge clk) disable iff (rst)
    !(phase[lrgc_pkg::PHASE_W-1] && phase[lrgc_pkg::PHASE_W-2]))
    else $error("phase out of range");
`endif

endmodule
